// ===== rtl/core/pem_pkg.sv =====
`default_nettype none

package pem_pkg;

  localparam int unsigned NsW    = 64;
  localparam int unsigned GnssW  = 63;
  localparam int unsigned CycW   = 32;
  localparam int unsigned CntW   = 32;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgW-1:0] NominalPeriodRst = 32'd1000000000;
  localparam logic [CfgW-1:0] WindowTolRst     = 32'd100;

  typedef enum logic [CfgIdxW-1:0] {
    RegNominalPeriod = 1'b0,
    RegWindowTol     = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ReqEdge     = 1'b0,
    ReqNewEpoch = 1'b1
  } req_e;

  typedef struct packed {
    logic [CfgW-1:0] nominal_period_ns;
    logic [CfgW-1:0] window_tolerance_ns;
  } cfg_t;

  typedef struct packed {
    logic             req_type;
    logic             epoch_ok;
    logic [GnssW-1:0] edge_gnss_ns;
    logic [CycW-1:0]  edge_cycles;
  } in_item_t;

  typedef struct packed {
    logic                   applied;
    logic                   first_edge;
    logic [NsW-1:0]         ledger_ns;
    logic signed [NsW-1:0]  phase_ns;
    logic [NsW-1:0]         interval_ns;
    logic [CycW-1:0]        interval_cycles;
    logic signed [NsW-1:0]  residual_ns;
    logic signed [NsW-1:0]  win_err_ns;
    logic                   window_mismatch;
    logic [CntW-1:0]        check_cnt;
    logic [CntW-1:0]        mismatch_cnt;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/pem_if.sv =====
`default_nettype none

interface pem_in_if import pem_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic             epoch_ok;
  logic [GnssW-1:0] edge_gnss_ns;
  logic [CycW-1:0]  edge_cycles;

  modport source (output valid, req_type, epoch_ok, edge_gnss_ns, edge_cycles,
                  input ready);
  modport sink   (input valid, req_type, epoch_ok, edge_gnss_ns, edge_cycles,
                  output ready);
endinterface

interface pem_out_if import pem_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  applied;
  logic                  first_edge;
  logic [NsW-1:0]        ledger_ns;
  logic signed [NsW-1:0] phase_ns;
  logic [NsW-1:0]        interval_ns;
  logic [CycW-1:0]       interval_cycles;
  logic signed [NsW-1:0] residual_ns;
  logic signed [NsW-1:0] win_err_ns;
  logic                  window_mismatch;
  logic [CntW-1:0]       check_cnt;
  logic [CntW-1:0]       mismatch_cnt;

  modport source (output valid, applied, first_edge, ledger_ns, phase_ns,
                  interval_ns, interval_cycles, residual_ns, win_err_ns,
                  window_mismatch, check_cnt, mismatch_cnt,
                  input ready);
  modport sink   (input valid, applied, first_edge, ledger_ns, phase_ns,
                  interval_ns, interval_cycles, residual_ns, win_err_ns,
                  window_mismatch, check_cnt, mismatch_cnt,
                  output ready);
endinterface

interface pem_cfg_if import pem_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgW-1:0]    wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pem_cfg_regs.sv =====
`default_nettype none

module pem_cfg_regs import pem_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pem_cfg_if.sink   cfg_i,
  output cfg_t      cfg_o
);

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nominal_period_ns   <= NominalPeriodRst;
      cfg_q.window_tolerance_ns <= WindowTolRst;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        RegNominalPeriod: cfg_q.nominal_period_ns   <= cfg_i.wdata;
        RegWindowTol:     cfg_q.window_tolerance_ns <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pem_edge_calc.sv =====
`default_nettype none

module pem_edge_calc import pem_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic fire_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output res_t      res_o
);

  logic [NsW-1:0]  ledger_q, ledger_d;
  logic [NsW-1:0]  prev_ns_q, prev_ns_d;
  logic [CycW-1:0] prev_cyc_q, prev_cyc_d;
  logic [CntW-1:0] checks_q, checks_d;
  logic [CntW-1:0] mism_q, mism_d;

  logic [NsW-1:0] t_ns;
  logic [NsW-1:0] period;
  logic [NsW-1:0] tol;
  logic [NsW-1:0] interval;
  logic [NsW-1:0] werr;
  logic [NsW-1:0] mag;
  logic           is_edge;
  logic           first;
  logic           mismatch;

  assign t_ns   = {1'b0, item_i.edge_gnss_ns};
  assign period = {{(NsW-CfgW){1'b0}}, cfg_i.nominal_period_ns};
  assign tol    = {{(NsW-CfgW){1'b0}}, cfg_i.window_tolerance_ns};

  always_comb begin
    is_edge  = (item_i.req_type == ReqEdge) && item_i.epoch_ok &&
               (item_i.edge_gnss_ns != '0);
    first    = (prev_ns_q == '0);
    interval = t_ns - prev_ns_q;
    werr     = interval - period;
    mag      = werr[NsW-1] ? (~werr + 1'b1) : werr;
    mismatch = !first && (mag > tol);

    ledger_d   = ledger_q;
    prev_ns_d  = prev_ns_q;
    prev_cyc_d = prev_cyc_q;
    checks_d   = checks_q;
    mism_d     = mism_q;
    res_o      = '0;

    if (item_i.req_type == ReqNewEpoch) begin
      ledger_d   = '0;
      prev_ns_d  = '0;
      prev_cyc_d = '0;
      checks_d   = '0;
      mism_d     = '0;
    end else if (is_edge) begin
      ledger_d   = first ? period : (ledger_q + period);
      prev_ns_d  = t_ns;
      prev_cyc_d = item_i.edge_cycles;
      if (!first) begin
        checks_d = checks_q + 1'b1;
        if (mismatch) mism_d = mism_q + 1'b1;
      end
      res_o.applied      = 1'b1;
      res_o.first_edge   = first;
      res_o.ledger_ns    = ledger_d;
      res_o.phase_ns     = t_ns - ledger_d;
      res_o.check_cnt    = checks_d;
      res_o.mismatch_cnt = mism_d;
      if (!first) begin
        res_o.interval_ns     = interval;
        res_o.interval_cycles = item_i.edge_cycles - prev_cyc_q;
        res_o.residual_ns     = period - interval;
        res_o.win_err_ns      = werr;
        res_o.window_mismatch = mismatch;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ledger_q   <= '0;
      prev_ns_q  <= '0;
      prev_cyc_q <= '0;
      checks_q   <= '0;
      mism_q     <= '0;
    end else if (fire_i) begin
      ledger_q   <= ledger_d;
      prev_ns_q  <= prev_ns_d;
      prev_cyc_q <= prev_cyc_d;
      checks_q   <= checks_d;
      mism_q     <= mism_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pps_edge_interval_monitor_top.sv =====
// A result passes from the input register to the result register; an accepted
// transaction waits in the input register while the result register is stalled.
// Throughput: one transaction per cycle unless the result sink stalls; the edge
// state (ledger, previous edge, counters) updates between input and result registers.
// Reset: rst_ni is asynchronous, active low; clears the pipeline valids and the
// edge state, and loads the period (1e9 ns) and tolerance (100 ns) registers.
`default_nettype none

module pps_edge_interval_monitor_top import pem_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pem_in_if.sink    in_i,
  pem_out_if.source out_o,
  pem_cfg_if.sink   cfg_i
);

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
  cfg_t cfg;

  pem_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Input register stage.
  logic     in_vld_q;
  in_item_t in_item_q;

  // Result register stage.
  logic out_vld_q;
  res_t res_q;
  res_t res_d;

  // The compute stage advances when the result slot is free or being drained.
  logic advance;
  logic in_fire;

  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q.req_type     <= in_i.req_type;
      in_item_q.epoch_ok     <= in_i.epoch_ok;
      in_item_q.edge_gnss_ns <= in_i.edge_gnss_ns;
      in_item_q.edge_cycles  <= in_i.edge_cycles;
    end
  end

  // Edge arithmetic and state; state commits only on advance so a stalled
  // item is evaluated exactly once.
  pem_edge_calc u_edge_calc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.applied         = res_q.applied;
  assign out_o.first_edge      = res_q.first_edge;
  assign out_o.ledger_ns       = res_q.ledger_ns;
  assign out_o.phase_ns        = res_q.phase_ns;
  assign out_o.interval_ns     = res_q.interval_ns;
  assign out_o.interval_cycles = res_q.interval_cycles;
  assign out_o.residual_ns     = res_q.residual_ns;
  assign out_o.win_err_ns      = res_q.win_err_ns;
  assign out_o.window_mismatch = res_q.window_mismatch;
  assign out_o.check_cnt       = res_q.check_cnt;
  assign out_o.mismatch_cnt    = res_q.mismatch_cnt;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

import pem_pkg::*;

class edge_ledger_sb;
  logic [CfgW-1:0]  nominal_ns;
  logic [CfgW-1:0]  tolerance_ns;
  logic [NsW-1:0]   ledger_ns;
  logic [NsW-1:0]   prev_ns;
  logic [CycW-1:0]  prev_cycles;
  logic [CntW-1:0]  checks;
  logic [CntW-1:0]  mismatches;
  res_t             expected_q[$];
  int unsigned      fail_count;

  function new();
    nominal_ns   = NominalPeriodRst;
    tolerance_ns = WindowTolRst;
    clear_edges();
    fail_count   = 0;
  endfunction

  function void clear_edges();
    ledger_ns   = '0;
    prev_ns     = '0;
    prev_cycles = '0;
    checks      = '0;
    mismatches  = '0;
  endfunction

  function void set_reg(cfg_idx_e idx, logic [CfgW-1:0] value);
    if (idx == RegNominalPeriod) nominal_ns = value;
    else tolerance_ns = value;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // New epoch and ignored edges give an all-zero result.
  function res_t predict(in_item_t it);
    res_t           r;
    logic [NsW-1:0] t;
    logic [NsW-1:0] nom;
    logic [NsW-1:0] werr;
    logic [NsW-1:0] mag;
    r   = '0;
    t   = {1'b0, it.edge_gnss_ns};
    nom = {32'b0, nominal_ns};
    if (it.req_type == ReqNewEpoch) begin
      clear_edges();
      return r;
    end
    if (!it.epoch_ok || t == '0) return r;
    r.applied = 1'b1;
    if (prev_ns == '0) begin
      r.first_edge = 1'b1;
      ledger_ns    = nom;
    end else begin
      ledger_ns         = ledger_ns + nom;
      r.interval_ns     = t - prev_ns;
      r.interval_cycles = it.edge_cycles - prev_cycles;
      werr              = r.interval_ns - nom;
      r.residual_ns     = nom - r.interval_ns;
      r.win_err_ns      = werr;
      mag               = werr[NsW-1] ? ('0 - werr) : werr;
      checks            = checks + 1'b1;
      if (mag > {32'b0, tolerance_ns}) begin
        r.window_mismatch = 1'b1;
        mismatches        = mismatches + 1'b1;
      end
    end
    prev_ns        = t;
    prev_cycles    = it.edge_cycles;
    r.ledger_ns    = ledger_ns;
    r.phase_ns     = t - ledger_ns;
    r.check_cnt    = checks;
    r.mismatch_cnt = mismatches;
    return r;
  endfunction

  function void log_input(in_item_t it);
    expected_q.push_back(predict(it));
  endfunction

  task report(string what);
    fail_count++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  task compare_field(string name, logic [NsW-1:0] got, logic [NsW-1:0] want);
    if (got !== want) report($sformatf("%s: got %h, want %h", name, got, want));
  endtask

  task check_result(res_t got);
    res_t want;
    if (expected_q.size() == 0) begin
      report("result with no transaction pending");
      return;
    end
    want = expected_q.pop_front();
    compare_field("applied", 64'(got.applied), 64'(want.applied));
    compare_field("first_edge", 64'(got.first_edge), 64'(want.first_edge));
    compare_field("ledger_ns", got.ledger_ns, want.ledger_ns);
    compare_field("phase_ns", got.phase_ns, want.phase_ns);
    compare_field("interval_ns", got.interval_ns, want.interval_ns);
    compare_field("interval_cycles", 64'(got.interval_cycles), 64'(want.interval_cycles));
    compare_field("residual_ns", got.residual_ns, want.residual_ns);
    compare_field("win_err_ns", got.win_err_ns, want.win_err_ns);
    compare_field("window_mismatch", 64'(got.window_mismatch), 64'(want.window_mismatch));
    compare_field("check_cnt", 64'(got.check_cnt), 64'(want.check_cnt));
    compare_field("mismatch_cnt", 64'(got.mismatch_cnt), 64'(want.mismatch_cnt));
  endtask
endclass

module tb;

  // Far beyond the slowest correct run.
  localparam int unsigned CycleLimit = 200000;

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;                    // no idling on either side while set

  logic [GnssW-1:0] t_cur;       // last reference time sent in a clean sequence
  logic [CycW-1:0]  cyc_cur;     // matching cycle counter capture
  int unsigned      cycle_count;
  res_t             seen;
  edge_ledger_sb    ledger;

  pem_in_if  in_if ();
  pem_out_if out_if ();
  pem_cfg_if cfg_if ();

  pps_edge_interval_monitor_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned idle_pct();
    return calm ? 0 : 10;
  endfunction

  function automatic in_item_t mk_item(req_e req, logic ready, logic [GnssW-1:0] ns,
                                       logic [CycW-1:0] cyc);
    in_item_t it;
    it.req_type     = req;
    it.epoch_ok     = ready;
    it.edge_gnss_ns = ns;
    it.edge_cycles  = cyc;
    return it;
  endfunction

  // Mostly clean edge trains with jitter around the tolerance boundary; the
  // rest is epoch restarts, ignored edges and edges at arbitrary times.
  function automatic in_item_t random_item();
    in_item_t       it;
    int unsigned    roll;
    logic [NsW-1:0] r64;
    logic [NsW-1:0] mag;
    logic [NsW-1:0] nom;
    logic [NsW-1:0] t_next;
    logic [CfgW-1:0] tol;
    roll            = $urandom_range(99);
    r64             = {$urandom, $urandom};
    it.req_type     = ReqEdge;
    it.epoch_ok     = 1'b1;
    it.edge_gnss_ns = r64[GnssW-1:0];
    it.edge_cycles  = $urandom;
    tol             = ledger.tolerance_ns;
    nom             = {32'b0, ledger.nominal_ns};
    if (roll < 3) begin
      it.req_type = ReqNewEpoch;
      it.epoch_ok = 1'($urandom_range(1));
      r64         = {$urandom, $urandom};
      t_cur       = r64[GnssW-1:0];
      cyc_cur     = $urandom;
    end else if (roll < 6) begin
      it.epoch_ok = 1'b0;
    end else if (roll < 8) begin
      it.edge_gnss_ns = '0;
    end else if (roll < 12) begin
      // arbitrary time: the train continues from here
      t_cur   = it.edge_gnss_ns;
      cyc_cur = it.edge_cycles;
    end else begin
      if ($urandom_range(4) == 0) mag = {32'b0, tol} + 64'($urandom_range(1));
      else if (tol < 32'h0010_0000) mag = 64'($urandom_range(0, 2 * tol + 40));
      else mag = 64'($urandom);
      if ($urandom_range(1) == 0) t_next = {1'b0, t_cur} + nom + mag;
      else t_next = {1'b0, t_cur} + nom - mag;
      t_cur = t_next[GnssW-1:0];
      if (t_cur == '0) t_cur = 63'd1;
      cyc_cur         = cyc_cur + 32'd100_000_000 + 32'($urandom_range(4095));
      it.edge_gnss_ns = t_cur;
      it.edge_cycles  = cyc_cur;
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < idle_pct()) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid        = 1'b1;
    in_if.req_type     = it.req_type;
    in_if.epoch_ok     = it.epoch_ok;
    in_if.edge_gnss_ns = it.edge_gnss_ns;
    in_if.edge_cycles  = it.edge_cycles;
    do @(posedge clk); while (!in_if.ready);
    ledger.log_input(it);
    @(negedge clk);
  endtask

  // Drain: wait until every expected result is in, then idle before returning.
  task automatic settle();
    in_if.valid = 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] value);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.wdata = value;
    do @(posedge clk); while (!cfg_if.ready);
    ledger.set_reg(idx, value);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic run_phase(int unsigned n_items, bit quiet);
    calm = quiet;
    repeat (n_items) send_item(random_item());
    settle();
    calm = 1'b0;
  endtask

  // Result sink stalls at random; no stalls during a quiet phase.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = ($urandom_range(99) >= idle_pct());
    end
  end

  // Sample at the rising edge, before the block updates its outputs.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      seen.applied         = out_if.applied;
      seen.first_edge      = out_if.first_edge;
      seen.ledger_ns       = out_if.ledger_ns;
      seen.phase_ns        = out_if.phase_ns;
      seen.interval_ns     = out_if.interval_ns;
      seen.interval_cycles = out_if.interval_cycles;
      seen.residual_ns     = out_if.residual_ns;
      seen.win_err_ns      = out_if.win_err_ns;
      seen.window_mismatch = out_if.window_mismatch;
      seen.check_cnt       = out_if.check_cnt;
      seen.mismatch_cnt    = out_if.mismatch_cnt;
      ledger.check_result(seen);
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    ledger             = new();
    calm               = 1'b0;
    t_cur              = 63'd1;
    cyc_cur            = '0;
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.req_type     = ReqEdge;
    in_if.epoch_ok     = 1'b0;
    in_if.edge_gnss_ns = '0;
    in_if.edge_cycles  = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = RegNominalPeriod;
    cfg_if.wdata       = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // --- directed: reset config (1 s period, 100 ns tolerance) ---
    send_item(mk_item(ReqEdge, 1'b0, 63'd123, 32'd7));              // epoch not ready
    send_item(mk_item(ReqEdge, 1'b1, 63'd0, 32'd7));                // zero time
    send_item(mk_item(ReqEdge, 1'b1, 63'd1_000_000_005, 32'd100));  // first edge
    // error exactly at tolerance: no mismatch
    send_item(mk_item(ReqEdge, 1'b1, 63'd2_000_000_105, 32'hFFFF_FFF0));
    // one past tolerance, cycle counter wrapped
    send_item(mk_item(ReqEdge, 1'b1, 63'd3_000_000_206, 32'h0000_0010));
    // short interval: negative error out of tolerance
    send_item(mk_item(ReqEdge, 1'b1, 63'd3_999_999_000, 32'h5A5A_5A5A));
    send_item(mk_item(ReqEdge, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
    send_item(mk_item(ReqEdge, 1'b1, 63'd1, 32'd0));                // time goes back
    send_item(mk_item(ReqNewEpoch, 1'b0, 63'd0, 32'd0));            // clear, not ready
    send_item(mk_item(ReqEdge, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
    send_item(mk_item(ReqNewEpoch, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
    send_item(mk_item(ReqEdge, 1'b1, 63'd5, 32'd0));                // phase far negative
    settle();

    // --- directed: tiny period, zero tolerance ---
    write_reg(RegNominalPeriod, 32'd2);
    write_reg(RegWindowTol, 32'd0);
    send_item(mk_item(ReqNewEpoch, 1'b1, 63'd9, 32'd9));
    send_item(mk_item(ReqEdge, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 32'd0));
    // interval wraps so the window error is the most negative value
    send_item(mk_item(ReqEdge, 1'b1, 63'd1, 32'd1));
    send_item(mk_item(ReqEdge, 1'b1, 63'd3, 32'd2));                // exact period
    send_item(mk_item(ReqEdge, 1'b1, 63'd4, 32'd3));                // off by one
    settle();

    // --- directed: largest period and tolerance ---
    write_reg(RegNominalPeriod, 32'hFFFF_FFFF);
    write_reg(RegWindowTol, 32'hFFFF_FFFF);
    send_item(mk_item(ReqEdge, 1'b1, 63'h2_0000_0002, 32'd4));      // error == tolerance
    send_item(mk_item(ReqEdge, 1'b1, 63'h4_0000_0001, 32'd5));      // one past
    send_item(mk_item(ReqEdge, 1'b1, 63'd1, 32'd6));
    send_item(mk_item(ReqNewEpoch, 1'b0, 63'd0, 32'd0));
    settle();

    // --- random phases across register settings ---
    write_reg(RegNominalPeriod, NominalPeriodRst);
    write_reg(RegWindowTol, WindowTolRst);
    run_phase(200, 1'b0);

    // back-to-back traffic, no idling on either side
    write_reg(RegNominalPeriod, 32'hFFFF_FFFF);
    write_reg(RegWindowTol, 32'd0);
    run_phase(150, 1'b1);

    write_reg(RegNominalPeriod, 32'd1);
    write_reg(RegWindowTol, 32'hFFFF_FFFF);
    run_phase(100, 1'b0);

    write_reg(RegNominalPeriod, $urandom | 32'd1);
    write_reg(RegWindowTol, 32'($urandom_range(5000)));
    run_phase(150, 1'b0);

    write_reg(RegNominalPeriod, NominalPeriodRst);
    write_reg(RegWindowTol, 32'd0);
    run_phase(150, 1'b0);

    // everything drained; linger to catch stray results
    repeat (10) @(posedge clk);
    if (ledger.fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
